/* rtl/pphs_pkg.sv */
// Shared types and constants for the preemptive priority heap scheduler.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package pphs_pkg;
   localparam int HeapDepth = 32;
   localparam int IdxW = $clog2(HeapDepth);
   localparam int CntW = $clog2(HeapDepth + 1);

   localparam logic [2:0] StAccepted = 3'd0;
   localparam logic [2:0] StFull     = 3'd1;
   localparam logic [2:0] StZero     = 3'd2;
   localparam logic [2:0] StIdle     = 3'd3;
   localparam logic [2:0] StRan      = 3'd4;
   localparam logic [2:0] StFinished = 3'd5;

   typedef struct packed {
      logic [7:0]  prio;
      logic [7:0]  id;
      logic [15:0] orig;
      logic [15:0] remain;
      logic [31:0] arrival;
      logic        started;
   } entry_type;

   typedef enum logic [3:0] {
      CmdNone, CmdLoad, CmdReject, CmdArrive, CmdIdle, CmdPop, CmdReadKids,
      CmdCmpKids, CmdDownPlace, CmdResult, CmdReadUp, CmdCmpUp, CmdUpPlace,
      CmdFinish
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic zero_burst;
      logic is_tick;
      logic at_root;
      logic has_kid;
      logic up_move;
      logic down_move;
      logic reinsert;
   } status_type;
endpackage
`default_nettype wire

/* rtl/pphs_datapath.sv */
// Heap memory, counters and sift logic of the scheduler.
// Depends on pphs_pkg; driven by pphs_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none
module pphs_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pphs_pkg::cmd_type cmd,
   input  wire logic              in_mode,
   input  wire logic [7:0]        in_id,
   input  wire logic [7:0]        in_prio,
   input  wire logic [15:0]       in_burst,
   output pphs_pkg::status_type   stat,
   output logic [2:0]             res_status,
   output logic [7:0]             res_id,
   output logic [31:0]            res_time,
   output logic                   res_first,
   output logic [31:0]            res_resp,
   output logic [31:0]            res_wait
);
   import pphs_pkg::*;

   entry_type mem [HeapDepth];
   entry_type a_ff, a_in, b_ff, c_ff;
   entry_type cur_ff, cur_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [31:0] time_ff, time_in;
   logic [IdxW-1:0] pos_ff, pos_in;
   logic mode_ff, mode_in;
   logic [7:0] id_ff, id_in, prio_ff, prio_in;
   logic [15:0] burst_ff, burst_in;
   logic [2:0] rs_ff, rs_in;
   logic [7:0] rid_ff, rid_in;
   logic [31:0] rt_ff, rt_in, rr_ff, rr_in, rw_ff, rw_in;
   logic rf_ff, rf_in;
   logic we;
   logic [IdxW-1:0] waddr, raddr0, raddr1;
   entry_type wdata;
   logic [IdxW:0] lidx, ridx, cnt_ext;
   logic [IdxW-1:0] parent;
   logic [32:0] done_w, sub_w;
   logic [15:0] rem_dec;
   logic l_take, r_take, has_kid, up_move, down_move, reins;
   logic [7:0] best_prio;

   assign lidx = {pos_ff, 1'b1};
   assign ridx = {pos_ff, 1'b0} + (IdxW+1)'(2);
   assign cnt_ext = (IdxW+1)'(count_ff);
   assign parent = (pos_ff - IdxW'(1)) >> 1;
   assign rem_dec = (cur_ff.remain != 16'd0) ? cur_ff.remain - 16'd1 : 16'd0;
   assign l_take = (b_ff.prio < a_ff.prio);
   assign best_prio = l_take ? b_ff.prio : a_ff.prio;
   assign r_take = (ridx < cnt_ext) && (c_ff.prio < best_prio);
   assign has_kid = (lidx < cnt_ext);
   assign up_move = (b_ff.prio > a_ff.prio);
   assign down_move = l_take | r_take;
   assign reins = (rem_dec != 16'd0);
   assign done_w = {1'b0, time_ff} + 33'd1;
   assign sub_w = {1'b0, cur_ff.arrival} + {17'd0, cur_ff.orig};

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      b_ff <= mem[raddr0];
      c_ff <= mem[raddr1];
   end

   always_comb begin
      we = 1'b0; waddr = pos_ff; wdata = a_ff;
      raddr0 = '0; raddr1 = '0;
      a_in = a_ff; cur_in = cur_ff; count_in = count_ff; time_in = time_ff;
      pos_in = pos_ff;
      mode_in = mode_ff; id_in = id_ff; prio_in = prio_ff; burst_in = burst_ff;
      rs_in = rs_ff; rid_in = rid_ff; rt_in = rt_ff; rr_in = rr_ff; rw_in = rw_ff;
      rf_in = rf_ff;
      case (cmd)
         CmdLoad: begin
            mode_in = in_mode; id_in = in_id; prio_in = in_prio; burst_in = in_burst;
            raddr0 = '0;
            raddr1 = IdxW'(count_ff - CntW'(1));
         end
         CmdReject: begin
            rs_in = (count_ff == CntW'(HeapDepth)) ? StFull : StZero;
            rid_in = id_ff; rt_in = time_ff; rf_in = 1'b0; rr_in = '0; rw_in = '0;
         end
         CmdArrive: begin
            a_in = '{prio: prio_ff, id: id_ff, orig: burst_ff, remain: burst_ff,
                     arrival: time_ff, started: 1'b0};
            pos_in = count_ff[IdxW-1:0];
            count_in = count_ff + CntW'(1);
            rs_in = StAccepted; rid_in = id_ff; rt_in = time_ff;
            rf_in = 1'b0; rr_in = '0; rw_in = '0;
         end
         CmdIdle: begin
            rs_in = StIdle; rid_in = '0; rt_in = time_ff; rf_in = 1'b0;
            rr_in = '0; rw_in = '0;
         end
         CmdPop: begin
            cur_in = b_ff;
            a_in = c_ff;
            pos_in = '0;
            count_in = count_ff - CntW'(1);
         end
         CmdReadKids: begin
            raddr0 = lidx[IdxW-1:0];
            raddr1 = ridx[IdxW-1:0];
         end
         CmdCmpKids: begin
            we = 1'b1;
            if (r_take) begin
               wdata = c_ff; pos_in = ridx[IdxW-1:0];
            end else if (l_take) begin
               wdata = b_ff; pos_in = lidx[IdxW-1:0];
            end
         end
         CmdDownPlace: we = 1'b1;
         CmdResult: begin
            rid_in = cur_ff.id; rt_in = time_ff;
            rf_in = ~cur_ff.started;
            rr_in = cur_ff.started ? 32'd0 :
                    (time_ff >= cur_ff.arrival ? time_ff - cur_ff.arrival : 32'd0);
            if (reins) begin
               rs_in = StRan; rw_in = '0;
               a_in = cur_ff;
               a_in.started = 1'b1;
               a_in.remain = rem_dec;
               pos_in = count_ff[IdxW-1:0];
               count_in = count_ff + CntW'(1);
            end else begin
               rs_in = StFinished;
               rw_in = done_w > sub_w ? 32'(done_w - sub_w) : 32'd0;
            end
         end
         CmdReadUp: raddr0 = parent;
         CmdCmpUp: begin
            we = 1'b1;
            if (up_move) begin
               wdata = b_ff; pos_in = parent;
            end
         end
         CmdUpPlace: we = 1'b1;
         CmdFinish: begin
            if (mode_ff && time_ff != 32'hFFFF_FFFF) time_in = time_ff + 32'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0; time_ff <= '0;
      end else begin
         count_ff <= count_in; time_ff <= time_in;
      end
      a_ff <= a_in; cur_ff <= cur_in; pos_ff <= pos_in;
      mode_ff <= mode_in; id_ff <= id_in; prio_ff <= prio_in; burst_ff <= burst_in;
      rs_ff <= rs_in; rid_ff <= rid_in; rt_ff <= rt_in; rr_ff <= rr_in;
      rw_ff <= rw_in; rf_ff <= rf_in;
   end

   always_comb begin
      stat.empty = (count_ff == '0);
      stat.full = (count_ff == CntW'(HeapDepth));
      stat.zero_burst = (burst_ff == '0);
      stat.is_tick = mode_ff;
      stat.at_root = (pos_ff == '0);
      stat.has_kid = has_kid;
      stat.up_move = up_move;
      stat.down_move = down_move;
      stat.reinsert = reins;
   end

   assign res_status = rs_ff;
   assign res_id = rid_ff;
   assign res_time = rt_ff;
   assign res_first = rf_ff;
   assign res_resp = rr_ff;
   assign res_wait = rw_ff;
endmodule
`default_nettype wire

/* rtl/pphs_ctrl.sv */
// Sequencing state machine of the scheduler.
// Depends on pphs_pkg; commands pphs_datapath.
`timescale 1ns / 1ps
`default_nettype none
module pphs_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   input  wire pphs_pkg::status_type stat,
   output pphs_pkg::cmd_type         cmd
);
   import pphs_pkg::*;

   typedef enum logic [3:0] {
      SIdle, SDecide, SDownRd, SDownCmp, SResult, SUpRd, SUpCmp, SFinish, SOut
   } state_type;

   state_type state_ff;
   logic out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SIdle; out_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            SIdle: if (in_valid) state_ff <= SDecide;
            SDecide: begin
               if (!stat.is_tick)
                  state_ff <= (stat.full || stat.zero_burst) ? SFinish : SUpRd;
               else
                  state_ff <= stat.empty ? SFinish : SDownRd;
            end
            SDownRd: state_ff <= stat.has_kid ? SDownCmp : SResult;
            SDownCmp: state_ff <= stat.down_move ? SDownRd : SResult;
            SResult: state_ff <= stat.reinsert ? SUpRd : SFinish;
            SUpRd: state_ff <= stat.at_root ? SFinish : SUpCmp;
            SUpCmp: state_ff <= stat.up_move ? SUpRd : SFinish;
            SFinish: begin
               state_ff <= SOut; out_valid_ff <= 1'b1;
            end
            SOut: if (out_ready) begin
               out_valid_ff <= 1'b0; state_ff <= SIdle;
            end
            default: state_ff <= SIdle;
         endcase
      end
   end

   always_comb begin
      cmd = CmdNone;
      case (state_ff)
         SIdle: cmd = in_valid ? CmdLoad : CmdNone;
         SDecide: begin
            if (!stat.is_tick)
               cmd = (stat.full || stat.zero_burst) ? CmdReject : CmdArrive;
            else
               cmd = stat.empty ? CmdIdle : CmdPop;
         end
         SDownRd: cmd = stat.has_kid ? CmdReadKids : CmdDownPlace;
         SDownCmp: cmd = CmdCmpKids;
         SResult: cmd = CmdResult;
         SUpRd: cmd = stat.at_root ? CmdUpPlace : CmdReadUp;
         SUpCmp: cmd = CmdCmpUp;
         SFinish: cmd = CmdFinish;
         default: cmd = CmdNone;
      endcase
   end

   assign in_ready = (state_ff == SIdle);
   assign out_valid = out_valid_ff;
endmodule
`default_nettype wire

/* rtl/preemptive_priority_heap_scheduler_top.sv */
// Top level of the preemptive priority heap scheduler.
// Instantiates pphs_ctrl and pphs_datapath; uses pphs_pkg.
//
// Channel  Direction  Content
// req_     in         tuser = mode, tdata = task_id, task_priority, burst_length
// rsp_     out        tdata = status, served_id, tick_time, first_service,
//                     first_wait, waiting_time
// One transaction is handled at a time. A rejected arrival or an idle tick goes from the
// decide state straight to the finish state, an accepted arrival through its sift-up, and
// a tick through its sift-down, the result state and the sift-up of a reinserted task.
// Each sift level takes a read state and a compare state, as memory reads are registered.
// Reset clears the heap count and the time; the heap memory needs no clearing.
// A stalled result holds the block; requests are taken again the cycle after it goes.
`timescale 1ns / 1ps
`default_nettype none
module preemptive_priority_heap_scheduler_top (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [31:0]  req_tdata,  // task_id, task_priority, burst_length
   input  wire logic         req_tuser,  // mode
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [111:0]      rsp_tdata   // status, served_id, tick_time,
                                         // first_service, first_wait,
                                         // waiting_time
);
   import pphs_pkg::*;

   cmd_type cmd;
   status_type stat;
   logic [2:0] r_status;
   logic [7:0] r_id;
   logic [31:0] r_time, r_resp, r_wait;
   logic r_first;

   pphs_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .stat(stat), .cmd(cmd)
   );

   pphs_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .in_mode(req_tuser),
      .in_id(req_tdata[7:0]), .in_prio(req_tdata[15:8]), .in_burst(req_tdata[31:16]),
      .stat(stat), .res_status(r_status), .res_id(r_id), .res_time(r_time),
      .res_first(r_first), .res_resp(r_resp), .res_wait(r_wait)
   );

   assign rsp_tdata = {4'b0000, r_wait, r_resp, r_first, r_time, r_id, r_status};
endmodule
`default_nettype wire

/* rtl/pphs_checker.sv */
// Port-level checks for the preemptive priority heap scheduler.
// Bound to preemptive_priority_heap_scheduler_top; uses pphs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pphs_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [111:0] rsp_tdata
);
   import pphs_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Result changed while stalled.");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("Request taken while a result waits.");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("Second request taken while one is in progress.");
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= StFinished)
      else $error("Status code out of range.");
   a_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] == StIdle |-> rsp_tdata[10:3] == 8'd0)
      else $error("Idle tick reports an id.");
endmodule

bind preemptive_priority_heap_scheduler_top pphs_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
`default_nettype wire

/* bench/tb_preemptive_priority_heap_scheduler_top.sv */
// Self-checking bench for the preemptive priority heap scheduler: arrivals and ticks are
// driven on the request stream and every response is compared with a local heap model.
// Depends on pphs_pkg and preemptive_priority_heap_scheduler_top.
`timescale 1ns / 1ps

module tb_preemptive_priority_heap_scheduler_top;
   import pphs_pkg::*;

   localparam int StallLimit = 20000;
   localparam logic ModeArrive = 1'b0;
   localparam logic ModeTick = 1'b1;

   typedef struct packed {
      logic [31:0] waiting;
      logic [31:0] response;
      logic        first;
      logic [31:0] tick_time;
      logic [7:0]  served;
      logic [2:0]  status;
   } sched_result_type;

   class sched_scoreboard;
      entry_type heap[HeapDepth];
      int count;
      logic [31:0] now;
      sched_result_type pending[$];
      int mismatches;

      function new();
         count = 0;
         now = '0;
         mismatches = 0;
      endfunction

      function void swap_entries(int a, int b);
         entry_type t;
         t = heap[a];
         heap[a] = heap[b];
         heap[b] = t;
      endfunction

      function void push_entry(entry_type e);
         int pos;
         int parent;
         pos = count;
         heap[pos] = e;
         count++;
         while (pos != 0) begin
            parent = (pos - 1) / 2;
            if (heap[parent].prio <= heap[pos].prio) break;
            swap_entries(parent, pos);
            pos = parent;
         end
      endfunction

      function void sink_root();
         int pos;
         int best;
         pos = 0;
         forever begin
            best = pos;
            if (2 * pos + 1 < count && heap[2 * pos + 1].prio < heap[best].prio)
               best = 2 * pos + 1;
            if (2 * pos + 2 < count && heap[2 * pos + 2].prio < heap[best].prio)
               best = 2 * pos + 2;
            if (best == pos) break;
            swap_entries(best, pos);
            pos = best;
         end
      endfunction

      function void note_request(logic mode, logic [7:0] id, logic [7:0] prio,
                                 logic [15:0] burst);
         sched_result_type r;
         entry_type e;
         longint done;
         longint sub;
         r = '0;
         r.tick_time = now;
         if (mode == ModeArrive) begin
            r.served = id;
            if (count >= HeapDepth) r.status = StFull;
            else if (burst == 16'd0) r.status = StZero;
            else begin
               e.prio = prio;
               e.id = id;
               e.orig = burst;
               e.remain = burst;
               e.arrival = now;
               e.started = 1'b0;
               push_entry(e);
               r.status = StAccepted;
            end
            pending.push_back(r);
            return;
         end
         if (count == 0) r.status = StIdle;
         else begin
            e = heap[0];
            count--;
            if (count >= 1) begin
               heap[0] = heap[count];
               sink_root();
            end
            r.served = e.id;
            if (!e.started) begin
               r.first = 1'b1;
               r.response = (now >= e.arrival) ? now - e.arrival : 32'd0;
               e.started = 1'b1;
            end
            if (e.remain > 0) e.remain--;
            if (e.remain > 0) begin
               push_entry(e);
               r.status = StRan;
            end else begin
               done = longint'(now) + 1;
               sub = longint'(e.arrival) + longint'(e.orig);
               r.status = StFinished;
               r.waiting = (done > sub) ? 32'(done - sub) : 32'd0;
            end
         end
         if (now != 32'hFFFF_FFFF) now++;
         pending.push_back(r);
      endfunction

      function void check_result(logic [111:0] data);
         sched_result_type got;
         sched_result_type want;
         got = data[107:0];
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected response %h", data);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"Mismatch: status %0d/%0d id %0d/%0d time %0d/%0d ",
                         "first %0d/%0d resp %0d/%0d wait %0d/%0d (expected/actual)"},
                        want.status, got.status, want.served, got.served,
                        want.tick_time, got.tick_time, want.first, got.first,
                        want.response, got.response, want.waiting, got.waiting);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [31:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;

   sched_scoreboard board = new();
   int idle_cycles = 0;

   preemptive_priority_heap_scheduler_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_request(logic mode, logic [7:0] id, logic [7:0] prio,
                               logic [15:0] burst);
      int g;
      g = gap_length();
      @(negedge clock);
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_tuser <= mode;
      req_tdata <= {burst, prio, id};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      board.note_request(mode, id, prio, burst);
   endtask

   task automatic send_arrival(int plen);
      logic [15:0] b;
      b = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, plen));
      if ($urandom_range(0, 40) == 0) b = 16'd0;
      send_request(ModeArrive, 8'($urandom), 8'($urandom_range(0, 255)), b);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= StallLimit) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      int g;
      forever begin
         @(negedge clock);
         g = ($urandom_range(0, 3) == 0) ? gap_length() : 0;
         if (g > 0) begin
            rsp_tready <= 1'b0;
            repeat (g) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      int n;
      int k;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_request(ModeTick, 8'hFF, 8'hFF, 16'hFFFF);
      send_request(ModeArrive, 8'h00, 8'h00, 16'h0000);
      send_request(ModeArrive, 8'hFF, 8'hFF, 16'h0003);
      send_request(ModeArrive, 8'h00, 8'h00, 16'h0002);
      send_request(ModeArrive, 8'h5A, 8'h80, 16'h0001);
      send_request(ModeArrive, 8'hA5, 8'h80, 16'h0001);
      repeat (10) send_request(ModeTick, 8'h00, 8'h00, 16'h0000);
      for (int i = 0; i < 33; i++)
         send_request(ModeArrive, 8'(i), 8'($urandom_range(0, 3)), 16'hFFFF);
      send_request(ModeTick, 8'h00, 8'h00, 16'h0000);
      send_request(ModeArrive, 8'h77, 8'h10, 16'h0000);
      n = 0;
      while (n < 900) begin
         if ($urandom_range(0, 1) == 0 && board.count < HeapDepth) begin
            send_arrival(6);
         end else if (board.count >= HeapDepth - 1 && $urandom_range(0, 2) == 0) begin
            send_arrival(6);
         end else begin
            send_request(ModeTick, 8'($urandom), 8'($urandom), 16'($urandom));
         end
         n++;
         if (board.count > 24 && $urandom_range(0, 3) == 0) begin
            k = $urandom_range(10, 60);
            repeat (k) send_request(ModeTick, 8'h00, 8'h00, 16'h0000);
            n += k;
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
